// File: rtl/core/mtv_pkg.sv
// shared constants, types and word functions of the twister generator
package mtv_pkg;

   localparam int unsigned TW_N  = 624;
   localparam int unsigned TW_M  = 397;
   localparam int unsigned TW_NM = TW_N - TW_M;
   localparam int unsigned IDX_W = $clog2(TW_N + 1);

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [31:0]      word_type;

   localparam word_type INIT_MULT = 32'd1812433253;
   localparam word_type MATRIX    = 32'h9908b0df;
   localparam word_type TEMPER_B  = 32'h9d2c5680;
   localparam word_type TEMPER_C  = 32'hefc60000;

   localparam idx_type IDX_LAST = idx_type'(TW_N - 1);
   localparam idx_type IDX_N    = idx_type'(TW_N);

   // operation codes of a request beat
   localparam logic OP_SEED = 1'b0;
   localparam logic OP_DRAW = 1'b1;

   // commands from the sequencer to the table engine
   typedef struct packed {
      logic     seed_go;
      logic     regen_go;
      word_type seed;
      idx_type  fetch_addr;
   } mtv_cmd_type;

   // status from the table engine
   typedef struct packed {
      logic     busy;
      word_type fetch_word;
   } mtv_sts_type;

   // twist with the matrix term taken from the current word
   function automatic word_type twist_word(word_type m, word_type u, word_type v);
      word_type mixed;
      mixed = {u[31], v[30:0]};
      return m ^ (mixed >> 1) ^ (u[0] ? MATRIX : '0);
   endfunction

   // output tempering
   function automatic word_type temper(word_type y);
      word_type t;
      t = y ^ (y >> 11);
      t = t ^ ((t << 7) & TEMPER_B);
      t = t ^ ((t << 15) & TEMPER_C);
      return t ^ (t >> 18);
   endfunction

   // index of the far word, offset by TW_M modulo TW_N
   function automatic idx_type far_index(idx_type i);
      return (i < idx_type'(TW_NM)) ? i + idx_type'(TW_M) : i - idx_type'(TW_NM);
   endfunction

   // following index, wrapping at the table end
   function automatic idx_type next_index(idx_type i);
      return (i == IDX_LAST) ? '0 : i + idx_type'(1);
   endfunction

endpackage

// File: rtl/core/mtv_if.sv
// valid/ready channel interfaces for request and response beats
interface mtv_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [31:0] seed_value;

   modport source (output valid, output op, output seed_value, input ready);
   modport sink   (input valid, input op, input seed_value, output ready);
endinterface

interface mtv_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] random_value;
   logic        not_seeded;

   modport source (output valid, output random_value, output not_seeded, input ready);
   modport sink   (input valid, input random_value, input not_seeded, output ready);
endinterface

// File: rtl/core/mersenne_twister_variant_prng_unit.sv
// top level of the twister generator: request sequencer, tempering and response register
//
//   channel  | dir | beat fields                 | accepted when
//   req_bus  | in  | op, seed_value              | valid && ready
//   rsp_bus  | out | random_value, not_seeded    | valid && ready
//
// a draw passes through accept, table read and temper into the response register
// a draw that finds the table used up first regenerates it in place
// a seed writes word 0 directly, each further word through the init multiplier, then a regeneration
// a draw before any seed skips the table read and answers with not_seeded set
// reset is synchronous and clears all control state; table contents are undefined until seeded
// a stalled response holds; seeds are still accepted meanwhile, draws wait at the response slot
module mersenne_twister_variant_prng_unit (
   input logic       clock,
   input logic       reset,
   mtv_req_if.sink   req_bus,
   mtv_rsp_if.source rsp_bus
);
   import mtv_pkg::*;

   localparam logic [1:0] T_IDLE  = 2'd0;
   localparam logic [1:0] T_BUSY  = 2'd1;
   localparam logic [1:0] T_FETCH = 2'd2;
   localparam logic [1:0] T_SEND  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic        seeded_ff, seeded_in;
   idx_type     pos_ff, pos_in;
   idx_type     left_ff, left_in;
   logic        pend_ff, pend_in;
   logic        ns_ff, ns_in;
   logic        rsp_valid_ff, rsp_valid_in;
   word_type    rsp_value_ff, rsp_value_in;
   logic        rsp_ns_ff, rsp_ns_in;

   logic        accept;
   logic        rsp_free;
   idx_type     pos_eff;
   mtv_cmd_type cmd;
   mtv_sts_type sts;

   mtv_engine u_engine (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sts   (sts)
   );

   assign req_bus.ready = (state_ff == T_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign pos_eff       = (pos_ff >= IDX_N) ? '0 : pos_ff;

   // request sequencer
   always_comb begin
      state_in       = state_ff;
      seeded_in      = seeded_ff;
      pos_in         = pos_ff;
      left_in        = left_ff;
      pend_in        = pend_ff;
      ns_in          = ns_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_value_in   = rsp_value_ff;
      rsp_ns_in      = rsp_ns_ff;
      cmd.seed_go    = 1'b0;
      cmd.regen_go   = 1'b0;
      cmd.seed       = req_bus.seed_value;
      cmd.fetch_addr = pos_eff;
      unique case (state_ff)
         T_IDLE: begin
            if (accept) begin
               if (req_bus.op == OP_SEED) begin
                  cmd.seed_go = 1'b1;
                  seeded_in   = 1'b1;
                  pend_in     = 1'b0;
                  state_in    = T_BUSY;
               end else if (!seeded_ff) begin
                  ns_in    = 1'b1;
                  state_in = T_SEND;
               end else if (left_ff == '0) begin
                  cmd.regen_go = 1'b1;
                  pend_in      = 1'b1;
                  state_in     = T_BUSY;
               end else begin
                  ns_in    = 1'b0;
                  state_in = T_FETCH;
               end
            end
         end
         T_BUSY: begin
            // table rebuilt: restart at word 0
            if (!sts.busy) begin
               left_in  = IDX_N;
               pos_in   = '0;
               ns_in    = 1'b0;
               state_in = pend_ff ? T_FETCH : T_IDLE;
            end
         end
         T_FETCH: begin
            state_in = T_SEND;
         end
         T_SEND: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ns_in    = ns_ff;
               rsp_value_in = ns_ff ? '0 : temper(sts.fetch_word);
               if (!ns_ff) begin
                  pos_in  = pos_eff + idx_type'(1);
                  left_in = left_ff - idx_type'(1);
               end
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         seeded_ff    <= 1'b0;
         pos_ff       <= '0;
         left_ff      <= '0;
         pend_ff      <= 1'b0;
         ns_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seeded_ff    <= seeded_in;
         pos_ff       <= pos_in;
         left_ff      <= left_in;
         pend_ff      <= pend_in;
         ns_ff        <= ns_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_ns_ff    <= rsp_ns_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.random_value = rsp_value_ff;
   assign rsp_bus.not_seeded   = rsp_ns_ff;

`ifndef SYNTH
   // an unseeded response always carries a zero word
   a_unseeded_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ns_ff) |-> rsp_value_ff == '0)
      else $error("unseeded response with non-zero value");

   // the sequencer only sits idle while the engine is idle
   a_idle_engine: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_IDLE) |-> !sts.busy)
      else $error("sequencer idle while engine busy");

   // a stalled response beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready)
         |=> (rsp_valid_ff && $stable(rsp_value_ff) && $stable(rsp_ns_ff)))
      else $error("stalled response changed");
`endif

endmodule

// File: rtl/core/mtv_ram.sv
// generic single write port ram with registered read
module mtv_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 624
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// File: rtl/core/mtv_engine.sv
// twister table engine: seeding, in-place regeneration and word fetch
module mtv_engine (
   input  logic                clock,
   input  logic                reset,
   input  mtv_pkg::mtv_cmd_type cmd,
   output mtv_pkg::mtv_sts_type sts
);
   import mtv_pkg::*;

   localparam logic [2:0] E_IDLE  = 3'd0;
   localparam logic [2:0] E_SMUL  = 3'd1;
   localparam logic [2:0] E_SADD  = 3'd2;
   localparam logic [2:0] E_PRIME = 3'd3;
   localparam logic [2:0] E_TWIST = 3'd4;

   logic [2:0] state_ff, state_in;
   idx_type    idx_ff, idx_in;
   word_type   prev_ff, prev_in;
   word_type   prod_ff, prod_in;
   idx_type    iss_ff, iss_in;
   idx_type    cmp_ff, cmp_in;
   logic       cmp_vld_ff, cmp_vld_in;
   logic       prime_ff, prime_in;
   word_type   cur_ff, cur_in;

   logic       ram_we;
   idx_type    wr_addr;
   word_type   wr_data;
   idx_type    rd_addr_a, rd_addr_b;
   word_type   rd_data_a, rd_data_b;

   // two copies of the table so that two words can be read each cycle
   mtv_ram #(.WIDTH(32), .DEPTH(TW_N)) u_ram_a (
      .clock (clock),
      .we    (ram_we),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (rd_addr_a),
      .rdata (rd_data_a)
   );

   mtv_ram #(.WIDTH(32), .DEPTH(TW_N)) u_ram_b (
      .clock (clock),
      .we    (ram_we),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (rd_addr_b),
      .rdata (rd_data_b)
   );

   // sequencer for seeding and the regeneration pipeline
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      prev_in    = prev_ff;
      prod_in    = prod_ff;
      iss_in     = iss_ff;
      cmp_in     = cmp_ff;
      cmp_vld_in = cmp_vld_ff;
      prime_in   = prime_ff;
      cur_in     = cur_ff;
      ram_we     = 1'b0;
      wr_addr    = idx_ff;
      wr_data    = prod_ff;
      rd_addr_a  = cmd.fetch_addr;
      rd_addr_b  = far_index(iss_ff);
      unique case (state_ff)
         E_IDLE: begin
            if (cmd.seed_go) begin
               ram_we   = 1'b1;
               wr_addr  = '0;
               wr_data  = cmd.seed;
               prev_in  = cmd.seed;
               idx_in   = idx_type'(1);
               state_in = E_SMUL;
            end else if (cmd.regen_go) begin
               state_in = E_PRIME;
            end
         end
         E_SMUL: begin
            prod_in  = INIT_MULT * (prev_ff ^ (prev_ff >> 30));
            state_in = E_SADD;
         end
         E_SADD: begin
            ram_we  = 1'b1;
            wr_addr = idx_ff;
            wr_data = prod_ff + word_type'(idx_ff);
            prev_in = wr_data;
            if (idx_ff == IDX_LAST) begin
               state_in = E_PRIME;
            end else begin
               idx_in   = idx_ff + idx_type'(1);
               state_in = E_SMUL;
            end
         end
         E_PRIME: begin
            rd_addr_a  = '0;
            iss_in     = '0;
            cmp_vld_in = 1'b0;
            prime_in   = 1'b1;
            state_in   = E_TWIST;
         end
         E_TWIST: begin
            // issue reads of the next and far words
            if (iss_ff != IDX_N) begin
               rd_addr_a = next_index(iss_ff);
               rd_addr_b = far_index(iss_ff);
               iss_in    = iss_ff + idx_type'(1);
            end
            cmp_vld_in = (iss_ff != IDX_N);
            cmp_in     = iss_ff;
            // compute and write back one word
            if (prime_ff) begin
               cur_in   = rd_data_a;
               prime_in = 1'b0;
            end else if (cmp_vld_ff) begin
               ram_we  = 1'b1;
               wr_addr = cmp_ff;
               wr_data = twist_word(rd_data_b, cur_ff, rd_data_a);
               cur_in  = rd_data_a;
               if (cmp_ff == IDX_LAST) begin
                  state_in = E_IDLE;
               end
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= E_IDLE;
         cmp_vld_ff <= 1'b0;
         prime_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= cmp_vld_in;
         prime_ff   <= prime_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      prev_ff <= prev_in;
      prod_ff <= prod_in;
      iss_ff  <= iss_in;
      cmp_ff  <= cmp_in;
      cur_ff  <= cur_in;
   end

   assign sts.busy       = (state_ff != E_IDLE);
   assign sts.fetch_word = rd_data_a;

`ifndef SYNTH
   // a twist write never hits a word being read for the twist in the same cycle
   a_twist_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == E_TWIST && ram_we && iss_ff != IDX_N)
         |-> (wr_addr != rd_addr_a && wr_addr != rd_addr_b))
      else $error("twist write collides with a read address");

   // commands only arrive while the engine is idle
   a_cmd_when_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.seed_go || cmd.regen_go) |-> state_ff == E_IDLE)
      else $error("engine command while busy");

   // no twist write is pending once the engine is idle
   a_idle_no_compute: assert property (@(posedge clock) disable iff (reset)
      (state_ff == E_IDLE) |-> !cmp_vld_ff)
      else $error("twist write pending while idle");
`endif

endmodule

// File: tb/tb_mersenne_twister_variant_prng_unit.sv
// testbench of the twister generator: directed and random seed and draw beats checked against a predictor
module tb_mersenne_twister_variant_prng_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import mtv_pkg::*;

   localparam int RUN_LIMIT   = 600000;
   localparam int TAIL_CYCLES = 2500;
   localparam int MIN_BEATS   = 1150;

   typedef struct {
      logic     op;
      word_type seed;
   } req_beat_type;

   typedef struct {
      word_type value;
      logic     unseeded;
   } draw_result_type;

   logic clock;
   logic reset;

   mtv_req_if req_bus ();
   mtv_rsp_if rsp_bus ();

   mersenne_twister_variant_prng_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // beats waiting to be sent and draw results still owed by the block
   req_beat_type    beats_to_send[$];
   draw_result_type draws_due[$];
   req_beat_type    next_beat;

   // predictor state
   word_type gen_table[TW_N];
   int       gen_pos;
   int       gen_left;
   logic     gen_seeded;

   int   mismatches;
   int   cycle_count;
   int   beats_taken;
   int   beats_total;
   int   send_idle_pct;
   int   recv_idle_pct;
   logic req_took;

   // free-running clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(string what, word_type got, word_type want);
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
      mismatches++;
   endtask

   // one twist step, matrix term chosen by the current word
   function automatic word_type twist_step(word_type far_w, word_type cur_w, word_type nxt_w);
      word_type joined;
      word_type res;
      joined = (cur_w & 32'h8000_0000) | (nxt_w & 32'h7fff_ffff);
      res    = far_w ^ (joined >> 1);
      if (cur_w[0])
         res = res ^ MATRIX;
      return res;
   endfunction

   function automatic word_type temper_word(word_type y);
      word_type t;
      t = y ^ (y >> 11);
      t = t ^ ((t << 7) & TEMPER_B);
      t = t ^ ((t << 15) & TEMPER_C);
      t = t ^ (t >> 18);
      return t;
   endfunction

   // in-place regeneration, lower indices already hold new words
   task automatic refill_table();
      for (int i = 0; i < TW_N; i++)
         gen_table[i] = twist_step(gen_table[(i + TW_M) % TW_N], gen_table[i],
                                   gen_table[(i + 1) % TW_N]);
      gen_left = TW_N;
      gen_pos  = 0;
   endtask

   // advance the predictor by one accepted beat
   task automatic predict_beat(logic op, word_type seed);
      draw_result_type r;
      word_type        prev;
      if (op == OP_SEED) begin
         gen_table[0] = seed;
         for (int i = 1; i < TW_N; i++) begin
            prev         = gen_table[i-1];
            gen_table[i] = INIT_MULT * (prev ^ (prev >> 30)) + word_type'(i);
         end
         refill_table();
         gen_seeded = 1'b1;
      end else if (!gen_seeded) begin
         r.value    = '0;
         r.unseeded = 1'b1;
         draws_due.push_back(r);
      end else begin
         if (gen_left == 0)
            refill_table();
         gen_left--;
         if (gen_pos >= TW_N)
            gen_pos = 0;
         r.value    = temper_word(gen_table[gen_pos]);
         r.unseeded = 1'b0;
         gen_pos++;
         draws_due.push_back(r);
      end
   endtask

   task automatic queue_beat(logic op, word_type seed);
      req_beat_type b;
      b.op   = op;
      b.seed = seed;
      beats_to_send.push_back(b);
   endtask

   // monitor: check response beats, predict accepted request beats
   always @(posedge clock) begin
      draw_result_type want;
      cycle_count++;
      if (cycle_count >= RUN_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         req_took <= !reset && req_bus.valid && req_bus.ready;
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (draws_due.size() == 0) begin
               report_mismatch("unexpected response, value", rsp_bus.random_value, '0);
            end else begin
               want = draws_due.pop_front();
               if (rsp_bus.random_value !== want.value)
                  report_mismatch("random_value", rsp_bus.random_value, want.value);
               if (rsp_bus.not_seeded !== want.unseeded)
                  report_mismatch("not_seeded", word_type'(rsp_bus.not_seeded),
                                  word_type'(want.unseeded));
            end
         end
         if (!reset && req_bus.valid && req_bus.ready) begin
            predict_beat(req_bus.op, req_bus.seed_value);
            beats_taken++;
         end
         // idling pattern follows progress through the stimulus
         if (beats_taken * 3 < beats_total) begin
            send_idle_pct = 25;
            recv_idle_pct = 53;
         end else if (beats_taken * 3 < beats_total * 2) begin
            send_idle_pct = 53;
            recv_idle_pct = 25;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      end
   end

   // request driver, fed from the pending queue
   always @(negedge clock) begin
      if (!reset && (!req_bus.valid || req_took)) begin
         if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_beat = beats_to_send.pop_front();
            req_bus.valid      <= 1'b1;
            req_bus.op         <= next_beat.op;
            req_bus.seed_value <= next_beat.seed;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      word_type seed;
      int       run_len;

      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.op         = OP_SEED;
      req_bus.seed_value = '0;
      rsp_bus.ready      = 1'b0;
      req_took           = 1'b0;
      mismatches         = 0;
      cycle_count        = 0;
      beats_taken        = 0;
      send_idle_pct      = 25;
      recv_idle_pct      = 53;
      gen_pos            = 0;
      gen_left           = 0;
      gen_seeded         = 1'b0;
      foreach (gen_table[i])
         gen_table[i] = '0;

      // directed: draws before any seed
      queue_beat(OP_DRAW, 32'h0000_0000);
      queue_beat(OP_DRAW, 32'hffff_ffff);
      queue_beat(OP_DRAW, 32'h5555_aaaa);
      // directed: seed extremes, each followed by one or more draws
      queue_beat(OP_SEED, 32'h0000_0000);
      queue_beat(OP_DRAW, 32'h0000_0000);
      queue_beat(OP_DRAW, 32'hffff_ffff);
      queue_beat(OP_DRAW, 32'h1234_5678);
      queue_beat(OP_SEED, 32'hffff_ffff);
      queue_beat(OP_DRAW, 32'haaaa_5555);
      queue_beat(OP_DRAW, 32'h0000_0000);
      queue_beat(OP_SEED, 32'h8000_0000);
      queue_beat(OP_DRAW, 32'hffff_ffff);
      queue_beat(OP_SEED, 32'h7fff_ffff);
      queue_beat(OP_DRAW, 32'h0000_0001);
      // directed: seeds back to back, the second must win
      queue_beat(OP_SEED, 32'h0000_0001);
      queue_beat(OP_SEED, 32'd5489);
      queue_beat(OP_DRAW, 32'h0000_0000);
      queue_beat(OP_DRAW, 32'hffff_ffff);
      queue_beat(OP_DRAW, 32'h8000_0000);

      // random: one long run that crosses a regeneration, then mixed runs
      queue_beat(OP_SEED, $urandom());
      repeat ($urandom_range(700, 630)) queue_beat(OP_DRAW, $urandom());
      while (beats_to_send.size() < MIN_BEATS) begin
         case ($urandom_range(15))
            0:       seed = 32'h0000_0000;
            1:       seed = 32'hffff_ffff;
            default: seed = $urandom();
         endcase
         queue_beat(OP_SEED, seed);
         if ($urandom_range(9) == 0)
            run_len = $urandom_range(680, 600);
         else
            run_len = $urandom_range(40, 0);
         // keep the total close to the target
         if (run_len > MIN_BEATS - beats_to_send.size())
            run_len = MIN_BEATS - beats_to_send.size();
         repeat (run_len) queue_beat(OP_DRAW, $urandom());
      end
      beats_total = beats_to_send.size();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // drain: everything sent and every draw answered
      while (beats_to_send.size() != 0 || req_bus.valid || draws_due.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
